// ===== rtl/adaptive_max_pool_argmax_defines.svh =====
// ----------------------------------------------------------------------------
// adaptive max pool argmax assertion macros
// concurrent property helpers used by the port checker
// ----------------------------------------------------------------------------
`ifndef ADAPTIVE_MAX_POOL_ARGMAX_DEFINES_SVH
`define ADAPTIVE_MAX_POOL_ARGMAX_DEFINES_SVH

// same-cycle implication, quiet during reset
`define AMP_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, quiet during reset
`define AMP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/amp_pkg.sv =====
// ----------------------------------------------------------------------------
// amp_pkg
// shared constants, widths and types of the adaptive max pool block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package amp_pkg;

  localparam int MAX_PLANE_HEIGHT = 256;
  localparam int MAX_PLANE_WIDTH  = 256;
  localparam int MAX_GRID_COLS    = 64;
  localparam int GRID_ROW_LIMIT   = 64;
  localparam int SAMPLE_BITS      = 16;

  // configuration register widths and indexes
  localparam int CFG_DATA_W  = 9;
  localparam int CFG_INDEX_W = 3;
  localparam logic [CFG_INDEX_W-1:0] REG_PLANE_HEIGHT = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PLANE_WIDTH  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_GRID_ROWS    = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_GRID_COLS    = 3'd3;

  // clamped sizes
  localparam int DIM_H_W = $clog2(MAX_PLANE_HEIGHT + 1);
  localparam int DIM_W_W = $clog2(MAX_PLANE_WIDTH + 1);
  localparam int GR_W    = $clog2(GRID_ROW_LIMIT + 1);
  localparam int GC_W    = $clog2(MAX_GRID_COLS + 1);

  // positions and bin indexes
  localparam int ROW_W = (MAX_PLANE_HEIGHT > 1) ? $clog2(MAX_PLANE_HEIGHT) : 1;
  localparam int COL_W = (MAX_PLANE_WIDTH > 1) ? $clog2(MAX_PLANE_WIDTH) : 1;
  localparam int PI_W  = (GRID_ROW_LIMIT > 1) ? $clog2(GRID_ROW_LIMIT) : 1;
  localparam int QI_W  = (MAX_GRID_COLS > 1) ? $clog2(MAX_GRID_COLS) : 1;
  localparam int IDX_W = (MAX_PLANE_HEIGHT * MAX_PLANE_WIDTH > 1) ?
                         $clog2(MAX_PLANE_HEIGHT * MAX_PLANE_WIDTH) : 1;

  // bound products, one spare bit for the sums
  localparam int ROW_PROD_W = $clog2(MAX_PLANE_HEIGHT * GRID_ROW_LIMIT + 1) + 1;
  localparam int COL_PROD_W = $clog2(MAX_PLANE_WIDTH * MAX_GRID_COLS + 1) + 1;

  // one stored bin entry
  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] val;
    logic [IDX_W-1:0]              idx;
  } word_t;

  localparam int WORD_W = $bits(word_t);

  // merge request sent at the end of a column segment
  typedef struct packed {
    logic            valid;
    logic [QI_W-1:0] q;
    logic [PI_W-1:0] p;
    logic            first;
    logic            emit;
    logic            ovl;
    logic            last;
    word_t           cand;
  } req_t;

endpackage

// ===== rtl/amp_ram.sv =====
// ----------------------------------------------------------------------------
// amp_ram
// simple dual port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module amp_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/amp_tracker.sv =====
// ----------------------------------------------------------------------------
// amp_tracker
// raster position, incremental bin bounds and per-row segment maximum
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module amp_tracker (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 restart,
  input  logic                                 advance,
  input  logic [amp_pkg::DIM_H_W-1:0]          h,
  input  logic [amp_pkg::DIM_W_W-1:0]          w,
  input  logic [amp_pkg::GR_W-1:0]             pr,
  input  logic [amp_pkg::GC_W-1:0]             qc,
  input  logic signed [amp_pkg::SAMPLE_BITS-1:0] sample,
  output amp_pkg::req_t                        req
);

  import amp_pkg::*;

  logic [ROW_W-1:0]      r;
  logic [COL_W-1:0]      c;
  logic [PI_W-1:0]       p;
  logic [QI_W-1:0]       q;
  logic [ROW_PROD_W-1:0] rp;
  logic [ROW_PROD_W-1:0] ph1;
  logic [COL_PROD_W-1:0] cq;
  logic [COL_PROD_W-1:0] qw1;
  logic [IDX_W-1:0]      pos;
  logic                  lo_first;
  logic                  fresh;
  word_t                 seg;
  logic                  seg_empty;

  logic [ROW_PROD_W-1:0] ph1_eff;
  logic [COL_PROD_W-1:0] qw1_eff;
  logic [ROW_PROD_W-1:0] row_sum;
  logic [COL_PROD_W-1:0] col_sum;
  logic                  row_end;
  logic                  row_ovl;
  logic                  seg_end;
  logic                  col_ovl;
  logic                  c_last;
  logic                  r_last;
  word_t                 here;
  word_t                 cand;

  // bounds of the live bins, loaded from the sizes after a restart
  assign ph1_eff = fresh ? ROW_PROD_W'(h) : ph1;
  assign qw1_eff = fresh ? COL_PROD_W'(w) : qw1;
  assign row_sum = rp + ROW_PROD_W'(pr);
  assign col_sum = cq + COL_PROD_W'(qc);
  assign row_end = (row_sum >= ph1_eff);
  assign row_ovl = (row_sum > ph1_eff);
  assign seg_end = (col_sum >= qw1_eff);
  assign col_ovl = (col_sum > qw1_eff);
  assign c_last  = ((DIM_W_W'(c) + DIM_W_W'(1)) == w);
  assign r_last  = ((DIM_H_W'(r) + DIM_H_W'(1)) == h);

  // running maximum of the segment, first sample wins a tie
  always_comb begin
    here.val = sample;
    here.idx = pos;
    if (seg_empty || (sample > seg.val)) begin
      cand = here;
    end else begin
      cand = seg;
    end
  end

  // merge request for the bins whose column segment closes here
  always_comb begin
    req.valid = seg_end;
    req.q     = q;
    req.p     = p;
    req.first = lo_first;
    req.emit  = row_end;
    req.ovl   = row_ovl;
    req.last  = ((GR_W'(p) + GR_W'(1)) == pr) && ((GC_W'(q) + GC_W'(1)) == qc);
    req.cand  = cand;
  end

  // position and bound counters
  always_ff @(posedge clk) begin
    if (rst || restart) begin
      r         <= '0;
      c         <= '0;
      p         <= '0;
      q         <= '0;
      rp        <= '0;
      cq        <= '0;
      pos       <= '0;
      lo_first  <= 1'b1;
      fresh     <= 1'b1;
      seg_empty <= 1'b1;
    end else if (advance) begin
      fresh <= 1'b0;
      ph1   <= ph1_eff;
      qw1   <= qw1_eff;
      // column side
      if (c_last) begin
        c   <= '0;
        cq  <= '0;
        q   <= '0;
        qw1 <= COL_PROD_W'(w);
      end else begin
        c  <= c + COL_W'(1);
        cq <= col_sum;
        if (seg_end) begin
          q   <= q + QI_W'(1);
          qw1 <= qw1_eff + COL_PROD_W'(w);
        end
      end
      // row side, once per row
      if (c_last) begin
        if (r_last) begin
          r        <= '0;
          rp       <= '0;
          p        <= '0;
          ph1      <= ROW_PROD_W'(h);
          lo_first <= 1'b1;
        end else begin
          r  <= r + ROW_W'(1);
          rp <= row_sum;
          if (row_end) begin
            p        <= p + PI_W'(1);
            ph1      <= ph1_eff + ROW_PROD_W'(h);
            lo_first <= !row_ovl;
          end else begin
            lo_first <= 1'b0;
          end
        end
      end
      // plane index
      if (c_last && r_last) begin
        pos <= '0;
      end else begin
        pos <= pos + IDX_W'(1);
      end
      // segment accumulator, shared column starts the next segment
      if (seg_end && !col_ovl) begin
        seg_empty <= 1'b1;
      end else begin
        seg_empty <= 1'b0;
      end
      if (seg_end && col_ovl) begin
        seg <= here;
      end else begin
        seg <= cand;
      end
    end
  end

endmodule

// ===== rtl/amp_merge.sv =====
// ----------------------------------------------------------------------------
// amp_merge
// read-modify-write of the bin store with forwarding, and the result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module amp_merge (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  accept,
  input  amp_pkg::req_t                         req,
  input  amp_pkg::word_t [1:0]                  rd_data,
  output logic                                  take,
  output logic [1:0]                            wr_en,
  output logic [amp_pkg::QI_W-1:0]              wr_addr,
  output amp_pkg::word_t [1:0]                  wr_data,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [amp_pkg::SAMPLE_BITS-1:0] max_value,
  output logic [15:0]                           max_index,
  output logic [5:0]                            bin_row,
  output logic [5:0]                            bin_col,
  output logic                                  last_of_plane
);

  import amp_pkg::*;

  logic  s1_valid;
  req_t  s1;
  logic  s1_fwd;
  word_t s1_fwd_word;
  logic  s1_go;
  word_t base;
  word_t merged;
  logic  fwd_next;
  word_t fwd_word_next;

  // stage one moves on unless its result finds the output register full and not taken
  assign s1_go = !s1.emit || !out_valid || out_ready;
  assign take  = !s1_valid || s1_go;

  // merge with stored entry, stored one wins a tie
  always_comb begin
    if (s1_fwd) begin
      base = s1_fwd_word;
    end else begin
      base = rd_data[s1.p[0]];
    end
    if (s1.first || (s1.cand.val > base.val)) begin
      merged = s1.cand;
    end else begin
      merged = base;
    end
  end

  // lower bin row gets the merge, a starting upper bin row gets the segment
  always_comb begin
    wr_addr = s1.q;
    for (int b = 0; b < 2; b++) begin
      wr_en[b]   = s1_valid && s1_go && ((b == int'(s1.p[0])) || s1.ovl);
      wr_data[b] = (b == int'(s1.p[0])) ? merged : s1.cand;
    end
  end

  // forward a write that lands on the entry just read
  always_comb begin
    fwd_next = s1_valid && s1_go && (s1.q == req.q) && ((s1.p[0] == req.p[0]) || s1.ovl);
    if (s1.p[0] == req.p[0]) begin
      fwd_word_next = merged;
    end else begin
      fwd_word_next = s1.cand;
    end
  end

  // stage one register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= req.valid;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
    if (accept) begin
      s1          <= req;
      s1_fwd      <= fwd_next;
      s1_fwd_word <= fwd_word_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_valid && s1_go && s1.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (s1_valid && s1_go && s1.emit) begin
      max_value     <= merged.val;
      max_index     <= 16'(merged.idx);
      bin_row       <= 6'(s1.p);
      bin_col       <= 6'(s1.q);
      last_of_plane <= s1.last;
    end
  end

endmodule

// ===== rtl/adaptive_max_pool_argmax.sv =====
// ----------------------------------------------------------------------------
// adaptive_max_pool_argmax
// adaptive 2-d max pooling with argmax over a raster stream of samples
// ----------------------------------------------------------------------------
// Takes one sample per cycle with no bubbles; the sample that closes a
// bin sends its result through the merge stage register into the output
// register, and the input only pauses while that register is full and
// not taken. Bin bounds
// are tracked by running products, so no division is done per sample. Each
// row of a bin is reduced to a segment maximum in registers, then merged
// into one of two bin stores (even and odd pooled rows, one entry per pooled
// column) by a read-modify-write with write-to-read forwarding, which sets
// the one sample per cycle rate. No clearing pass is needed after reset:
// the first row of each bin loads its entry. A write to any of the four
// configuration indexes restarts the plane.
`timescale 1ns / 1ps

module adaptive_max_pool_argmax (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [amp_pkg::CFG_INDEX_W-1:0]       cfg_index,
  input  logic [amp_pkg::CFG_DATA_W-1:0]        cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [amp_pkg::SAMPLE_BITS-1:0] sample_value,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [amp_pkg::SAMPLE_BITS-1:0] max_value,
  output logic [15:0]                           max_index,
  output logic [5:0]                            bin_row,
  output logic [5:0]                            bin_col,
  output logic                                  last_of_plane
);

  import amp_pkg::*;

  logic [8:0]         plane_height;
  logic [8:0]         plane_width;
  logic [6:0]         grid_rows;
  logic [6:0]         grid_cols;
  logic               cfg_hit;
  logic [DIM_H_W-1:0] h;
  logic [DIM_W_W-1:0] w;
  logic [GR_W-1:0]    pr_lim;
  logic [GC_W-1:0]    qc_lim;
  logic [GR_W-1:0]    pr;
  logic [GC_W-1:0]    qc;
  logic               accept;
  req_t               req;
  word_t [1:0]        rd_data;
  logic [1:0]         wr_en;
  logic [QI_W-1:0]    wr_addr;
  word_t [1:0]        wr_data;

  // configuration registers
  always_comb begin
    case (cfg_index)
      REG_PLANE_HEIGHT: cfg_hit = cfg_we;
      REG_PLANE_WIDTH:  cfg_hit = cfg_we;
      REG_GRID_ROWS:    cfg_hit = cfg_we;
      REG_GRID_COLS:    cfg_hit = cfg_we;
      default:          cfg_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      plane_height <= 9'd1;
      plane_width  <= 9'd1;
      grid_rows    <= 7'd1;
      grid_cols    <= 7'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PLANE_HEIGHT: plane_height <= cfg_data;
        REG_PLANE_WIDTH:  plane_width  <= cfg_data;
        REG_GRID_ROWS:    grid_rows    <= cfg_data[6:0];
        REG_GRID_COLS:    grid_cols    <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // clamp sizes: zero acts as one, then limits, grid no larger than plane
  always_comb begin
    if (plane_height == '0) begin
      h = DIM_H_W'(1);
    end else if (32'(plane_height) > MAX_PLANE_HEIGHT) begin
      h = DIM_H_W'(MAX_PLANE_HEIGHT);
    end else begin
      h = DIM_H_W'(plane_height);
    end
    if (plane_width == '0) begin
      w = DIM_W_W'(1);
    end else if (32'(plane_width) > MAX_PLANE_WIDTH) begin
      w = DIM_W_W'(MAX_PLANE_WIDTH);
    end else begin
      w = DIM_W_W'(plane_width);
    end
    if (grid_rows == '0) begin
      pr_lim = GR_W'(1);
    end else if (32'(grid_rows) > GRID_ROW_LIMIT) begin
      pr_lim = GR_W'(GRID_ROW_LIMIT);
    end else begin
      pr_lim = GR_W'(grid_rows);
    end
    if (grid_cols == '0) begin
      qc_lim = GC_W'(1);
    end else if (32'(grid_cols) > MAX_GRID_COLS) begin
      qc_lim = GC_W'(MAX_GRID_COLS);
    end else begin
      qc_lim = GC_W'(grid_cols);
    end
    pr = (32'(pr_lim) > 32'(h)) ? GR_W'(h) : pr_lim;
    qc = (32'(qc_lim) > 32'(w)) ? GC_W'(w) : qc_lim;
  end

  assign accept = in_valid && in_ready;

  // position and segment tracking
  amp_tracker u_tracker (
    .clk     (clk),
    .rst     (rst),
    .restart (cfg_hit),
    .advance (accept),
    .h       (h),
    .w       (w),
    .pr      (pr),
    .qc      (qc),
    .sample  (sample_value),
    .req     (req)
  );

  // bin stores, even and odd pooled rows
  for (genvar b = 0; b < 2; b++) begin : g_bank
    amp_ram #(
      .DEPTH (MAX_GRID_COLS),
      .WIDTH (WORD_W)
    ) u_ram (
      .clk     (clk),
      .rd_en   (accept),
      .rd_addr (req.q),
      .rd_data (rd_data[b]),
      .wr_en   (wr_en[b]),
      .wr_addr (wr_addr),
      .wr_data (wr_data[b])
    );
  end

  // merge stage and result register
  amp_merge u_merge (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .req           (req),
    .rd_data       (rd_data),
    .take          (in_ready),
    .wr_en         (wr_en),
    .wr_addr       (wr_addr),
    .wr_data       (wr_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .max_value     (max_value),
    .max_index     (max_index),
    .bin_row       (bin_row),
    .bin_col       (bin_col),
    .last_of_plane (last_of_plane)
  );

endmodule

// ===== rtl/amp_checker.sv =====
// ----------------------------------------------------------------------------
// amp_checker
// port level checks of the adaptive max pool block, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "adaptive_max_pool_argmax_defines.svh"

module amp_checker (
  input logic                                  clk,
  input logic                                  rst,
  input logic                                  in_valid,
  input logic                                  in_ready,
  input logic                                  out_valid,
  input logic                                  out_ready,
  input logic signed [amp_pkg::SAMPLE_BITS-1:0] max_value,
  input logic [15:0]                           max_index
);

  import amp_pkg::*;

  // a stalled result holds
  `AMP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(max_value) && $stable(max_index), "result changed while stalled")

  // input side never waits on an empty output register
  `AMP_ASSERT_IMPL(a_ready_free, !out_valid, in_ready, "input blocked with output free")

  // a fresh result must come from an earlier taken request
  `AMP_ASSERT_IMPL(a_out_cause, $rose(out_valid), $past(in_valid && in_ready, 2), "result without a request")

endmodule

bind adaptive_max_pool_argmax amp_checker u_checker (.*);
